/* rtl/pdag_neighborhood_query_unit_assert.svh */
// ----------------------------------------------------------------------------
// PDAG neighborhood query unit: assertion macros
// Concurrent checks on clk with rst_n low as the disable condition.
// ----------------------------------------------------------------------------
`ifndef PDAG_NEIGHBORHOOD_QUERY_UNIT_ASSERT_SVH
`define PDAG_NEIGHBORHOOD_QUERY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define PNQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pnq same-cycle check failed");

// ante holds -> cons holds in the next cycle
`define PNQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pnq next-cycle check failed");

`else

`define PNQ_ASSERT_IMPL(lbl, ante, cons)
`define PNQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/pnq_pkg.sv */
// ----------------------------------------------------------------------------
// pnq_pkg
// Shared types and constants of the PDAG neighborhood query unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pnq_pkg;

  localparam int MASK_W = 64;  // target / neighbor mask width
  localparam int NODE_W = 6;   // node index field width
  localparam int CNT_W  = 7;   // node_count register width

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_NBHD  = 2'd1,
    FN_SAME  = 2'd2,
    FN_CLEAR = 2'd3
  } pnq_func_t;

  typedef struct packed {
    pnq_func_t           func;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic                edge_bit;
    logic [MASK_W-1:0]   target_mask;
  } pnq_item_t;

  typedef struct packed {
    logic [MASK_W-1:0]   neighbor_mask;
    logic                same_neighborhood;
    logic                status;
  } pnq_res_t;

endpackage

`default_nettype wire

/* rtl/pnq_ifs.sv */
// ----------------------------------------------------------------------------
// pnq_in_if / pnq_out_if
// Valid/ready channels for query items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  node_a;
  logic [5:0]  node_b;
  logic        edge_bit;
  logic [63:0] target_mask;

  modport source (output valid, output func, output node_a, output node_b,
                  output edge_bit, output target_mask, input ready);
  modport sink   (input valid, input func, input node_a, input node_b,
                  input edge_bit, input target_mask, output ready);
endinterface

interface pnq_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] neighbor_mask;
  logic        same_neighborhood;
  logic        status;

  modport source (output valid, output neighbor_mask, output same_neighborhood,
                  output status, input ready);
  modport sink   (input valid, input neighbor_mask, input same_neighborhood,
                  input status, output ready);
endinterface

`default_nettype wire

/* rtl/pnq_adj_ram.sv */
// ----------------------------------------------------------------------------
// pnq_adj_ram
// One adjacency store: 1R1W synchronous RAM with per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pnq_adj_ram import pnq_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     clr,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q_r <= mem[raddr];
  end

  // valid bits: an entry never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

/* rtl/pnq_core.sv */
// ----------------------------------------------------------------------------
// pnq_core
// Sequencer: clear, edge read-modify-write, two-pass neighborhood scan, pair test.
// ----------------------------------------------------------------------------
`default_nettype none

module pnq_core import pnq_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [CNT_W-1:0]             lcount,
  input  wire logic                         item_valid,
  input  wire pnq_item_t                    item,
  output logic                              item_ready,
  output logic                              res_valid,
  output pnq_res_t                          res,
  input  wire logic                         res_ready,
  output logic                              ram_clr,
  output logic [$clog2(MAX_NODES)-1:0]      row_raddr,
  output logic [$clog2(MAX_NODES)-1:0]      col_raddr,
  input  wire logic [MAX_NODES-1:0]         row_rdata,
  input  wire logic [MAX_NODES-1:0]         col_rdata,
  output logic                              ram_we,
  output logic [$clog2(MAX_NODES)-1:0]      row_waddr,
  output logic [$clog2(MAX_NODES)-1:0]      col_waddr,
  output logic [MAX_NODES-1:0]              row_wdata,
  output logic [MAX_NODES-1:0]              col_wdata
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int W  = MAX_NODES;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WR_RD, S_WR_WB, S_SA_RD, S_SB_RD, S_SB_CHK, S_P1, S_P2, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  pnq_func_t       func_r, func_nxt;
  logic [AW-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic            bit_r, bit_nxt;
  logic [W-1:0]    tgt_r, tgt_nxt;
  logic [W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]    kids_r, kids_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic            iss_r, iss_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            status_r, status_nxt;
  logic            same_r, same_nxt;

  logic [MASK_W-1:0] live64;
  logic [W-1:0]      live_w;
  logic              a_ok, b_ok, t_err;

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      live64[i] = (CNT_W'(i) < lcount);
    end
  end
  assign live_w = live64[W-1:0];
  assign a_ok   = ({1'b0, item.node_a} < lcount);
  assign b_ok   = ({1'b0, item.node_b} < lcount);
  assign t_err  = |(item.target_mask & ~live64);

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.neighbor_mask     = (func_r == FN_NBHD) ? MASK_W'(acc_r & ~tgt_r) : '0;
  assign res.same_neighborhood = same_r;
  assign res.status            = status_r;

  // write-back of one edge: row a gets bit b, column b gets bit a
  always_comb begin
    row_waddr = a_r;
    col_waddr = b_r;
    row_wdata = row_rdata;
    col_wdata = col_rdata;
    row_wdata[b_r] = bit_r;
    col_wdata[a_r] = bit_r;
    ram_we = (state_r == S_WR_WB);
  end

  // read address: scan counter by default, item nodes for single lookups
  always_comb begin
    row_raddr = cnt_r;
    col_raddr = cnt_r;
    unique case (state_r)
      S_WR_RD: begin
        row_raddr = a_r;
        col_raddr = b_r;
      end
      S_SA_RD: begin
        row_raddr = a_r;
        col_raddr = a_r;
      end
      S_SB_RD: begin
        row_raddr = b_r;
        col_raddr = b_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    bit_nxt    = bit_r;
    tgt_nxt    = tgt_r;
    acc_nxt    = acc_r;
    kids_nxt   = kids_r;
    cnt_nxt    = cnt_r;
    iss_nxt    = iss_r;
    rd_ok_nxt  = 1'b0;
    rd_idx_nxt = rd_idx_r;
    status_nxt = status_r;
    same_nxt   = same_r;
    ram_clr    = 1'b0;

    // scan issue side, shared by both passes
    if ((state_r == S_P1 || state_r == S_P2) && iss_r) begin
      rd_ok_nxt  = 1'b1;
      rd_idx_nxt = cnt_r;
      if (cnt_r == LAST_IDX) begin
        iss_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          func_nxt   = item.func;
          a_nxt      = item.node_a[AW-1:0];
          b_nxt      = item.node_b[AW-1:0];
          bit_nxt    = item.edge_bit;
          tgt_nxt    = item.target_mask[W-1:0];
          acc_nxt    = '0;
          kids_nxt   = '0;
          cnt_nxt    = '0;
          iss_nxt    = 1'b1;
          status_nxt = 1'b0;
          same_nxt   = 1'b0;
          state_nxt  = S_DONE;
          unique case (item.func)
            FN_WRITE: begin
              status_nxt = !(a_ok && b_ok);
              // diagonal writes are dropped silently
              if (a_ok && b_ok && item.node_a != item.node_b) begin
                state_nxt = S_WR_RD;
              end
            end
            FN_NBHD: begin
              status_nxt = t_err;
              if (!t_err) begin
                state_nxt = S_P1;
              end
            end
            FN_SAME: begin
              status_nxt = !(a_ok && b_ok);
              same_nxt   = a_ok && b_ok && item.node_a == item.node_b;
              if (a_ok && b_ok && item.node_a != item.node_b) begin
                state_nxt = S_SA_RD;
              end
            end
            FN_CLEAR: begin
              ram_clr = 1'b1;
            end
          endcase
        end
      end
      S_WR_RD:  state_nxt = S_WR_WB;
      S_WR_WB:  state_nxt = S_DONE;
      S_SA_RD:  state_nxt = S_SB_RD;
      S_SB_RD: begin
        // node a: adjacency in acc, directed children in kids
        acc_nxt   = row_rdata | col_rdata;
        kids_nxt  = row_rdata & ~col_rdata & live_w;
        state_nxt = S_SB_CHK;
      end
      S_SB_CHK: begin
        same_nxt  = acc_r[b_r] || (|(kids_r & row_rdata & ~col_rdata & live_w));
        state_nxt = S_DONE;
      end
      S_P1: begin
        // targets: adjacent nodes, plus collect directed children
        if (rd_ok_r && tgt_r[rd_idx_r]) begin
          acc_nxt  = acc_r | ((row_rdata | col_rdata) & live_w);
          kids_nxt = kids_r | (row_rdata & ~col_rdata & live_w);
        end
        if (rd_ok_r && !iss_r) begin
          state_nxt = S_P2;
          cnt_nxt   = '0;
          iss_nxt   = 1'b1;
          rd_ok_nxt = 1'b0;
        end
      end
      S_P2: begin
        // children: add their directed parents (spouses)
        if (rd_ok_r && kids_r[rd_idx_r]) begin
          acc_nxt = acc_r | (col_rdata & ~row_rdata & live_w);
        end
        if (rd_ok_r && !iss_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      iss_r    <= 1'b0;
      rd_ok_r  <= 1'b0;
      func_r   <= FN_WRITE;
      status_r <= 1'b0;
      same_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      iss_r    <= iss_nxt;
      rd_ok_r  <= rd_ok_nxt;
      func_r   <= func_nxt;
      status_r <= status_nxt;
      same_r   <= same_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    bit_r    <= bit_nxt;
    tgt_r    <= tgt_nxt;
    acc_r    <= acc_nxt;
    kids_r   <= kids_nxt;
    cnt_r    <= cnt_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

endmodule

`default_nettype wire

/* rtl/pdag_neighborhood_query_unit.sv */
// A neighborhood query makes two full row scans; an edge write is one read-modify-write.
// One item at a time: the next item is taken in the cycle after the result is buffered.
// Reset (sync, active low): empty graph via per-row valid bits, node_count = 64.
// ----------------------------------------------------------------------------
// pdag_neighborhood_query_unit
// Adjacency store of a partially directed graph with neighborhood queries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pdag_neighborhood_query_unit_assert.svh"

module pdag_neighborhood_query_unit import pnq_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  pnq_in_if.sink                in_ch,
  pnq_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_NODES);

  // node_count register; effective count saturates at MAX_NODES
  logic [CNT_W-1:0] cfg_node_count_r;
  logic [CNT_W-1:0] lcount;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_node_count_r <= CNT_RESET;
    end else if (cfg_we) begin
      cfg_node_count_r <= cfg_wdata;
    end
  end

  assign lcount = (cfg_node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                         : cfg_node_count_r;

  // input item unpack
  pnq_item_t item;
  assign item.func        = pnq_func_t'(in_ch.func);
  assign item.node_a      = in_ch.node_a;
  assign item.node_b      = in_ch.node_b;
  assign item.edge_bit    = in_ch.edge_bit;
  assign item.target_mask = in_ch.target_mask;

  logic           core_ready;
  logic           core_res_valid;
  pnq_res_t       core_res;
  logic           core_res_ready;
  logic           ram_clr, ram_we;
  logic [AW-1:0]  row_raddr, col_raddr, row_waddr, col_waddr;
  logic [MAX_NODES-1:0] row_rdata, col_rdata, row_wdata, col_wdata;

  assign in_ch.ready = core_ready;

  // rows: entry a bit b = mark a->b; columns hold the transpose
  pnq_adj_ram #(.DEPTH(MAX_NODES), .WIDTH(MAX_NODES)) u_rows (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ram_clr),
    .we    (ram_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  pnq_adj_ram #(.DEPTH(MAX_NODES), .WIDTH(MAX_NODES)) u_cols (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ram_clr),
    .we    (ram_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  pnq_core #(.MAX_NODES(MAX_NODES)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .lcount     (lcount),
    .item_valid (in_ch.valid),
    .item       (item),
    .item_ready (core_ready),
    .res_valid  (core_res_valid),
    .res        (core_res),
    .res_ready  (core_res_ready),
    .ram_clr    (ram_clr),
    .row_raddr  (row_raddr),
    .col_raddr  (col_raddr),
    .row_rdata  (row_rdata),
    .col_rdata  (col_rdata),
    .ram_we     (ram_we),
    .row_waddr  (row_waddr),
    .col_waddr  (col_waddr),
    .row_wdata  (row_wdata),
    .col_wdata  (col_wdata)
  );

  // output register: frees the core while a result waits downstream
  logic     out_valid_r;
  pnq_res_t out_res_r;

  assign core_res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_r <= core_res_valid;
    end
    if (core_res_valid && core_res_ready) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.neighbor_mask     = out_res_r.neighbor_mask;
  assign out_ch.same_neighborhood = out_res_r.same_neighborhood;
  assign out_ch.status            = out_res_r.status;

  // checks
  logic out_mask_zero;
  logic out_no_answer;
  assign out_mask_zero = (out_res_r.neighbor_mask == '0);
  assign out_no_answer = out_mask_zero && !out_res_r.same_neighborhood;

  `PNQ_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `PNQ_ASSERT_IMPL(a_err_result_clean, out_valid_r && out_res_r.status, out_no_answer)
  `PNQ_ASSERT_IMPL(a_one_answer_kind, out_valid_r && out_res_r.same_neighborhood, out_mask_zero)

endmodule

`default_nettype wire
